FILE: rtl/core/multichannel_pipe_fifo_core_defines.svh
// Assertion macros used by the checker file of the byte pipe block
`ifndef MULTICHANNEL_PIPE_FIFO_CORE_DEFINES_SVH
`define MULTICHANNEL_PIPE_FIFO_CORE_DEFINES_SVH

// Concurrent check, switched off while reset is high
`define MCPF_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also watches the reset cycles
`define MCPF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mcpf_pkg.sv
// Types and codes of the multichannel byte pipe block
`timescale 1ns / 1ps
package mcpf_pkg;

  // Item kinds
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_IN_USE      = 3'd1;
  localparam logic [2:0] ST_WRONG_DIR   = 3'd2;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
  localparam logic [2:0] ST_EOS         = 3'd4;

  localparam int FILL_W = 13;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] port;
    logic [7:0] data_in;
    logic       last_of_call;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        data_out;
    logic [FILL_W-1:0] fill_level;
    logic              last_out;
  } out_item_t;

endpackage

FILE: rtl/core/mcpf_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its value between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/multichannel_pipe_fifo_core.sv
// Multichannel byte pipe block: port state, ring pointers and the byte store
//
// Usage: PIPE_COUNT byte pipes, each a ring of PIPE_DEPTH bytes. Port 2p
// writes pipe p, port 2p+1 reads it. Each item on the in channel is an open,
// close, byte write or byte read on one port and gives exactly one result on
// the out channel (status, byte read, fill level, last mark copy).
// A result passes through the result stage, which takes the registered read
// of the byte store, and then through the output register.
// Throughput: one item per cycle unless a receiver stall fills both registers;
// counters, pointers and port flags are updated in the cycle of the transfer,
// and the store's single write and single read port serve each item's byte access, if it has one.
// Reset clears all port flags, read pointers and byte counts; the store is
// not cleared, since no read reaches an entry before it is written.
// When the receiver stalls, the output register holds its result and the
// stage behind it still fills, so input stops only when both are occupied.
`timescale 1ns / 1ps
module multichannel_pipe_fifo_core #(
  parameter int PIPE_DEPTH = 4096,
  parameter int PIPE_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcpf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcpf_pkg::out_item_t out_data
);
  import mcpf_pkg::*;

  localparam int PIPE_IDX_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int PORT_IDX_W = PIPE_IDX_W + 1;
  localparam int PORT_NUM   = 2 * PIPE_COUNT;
  localparam int PTR_W      = $clog2(PIPE_DEPTH);
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
  localparam int MEM_DEPTH  = PIPE_COUNT * PIPE_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(PIPE_DEPTH);
  localparam logic [CNT_W:0]    DEPTH_SUM   = (CNT_W + 1)'(PIPE_DEPTH);
  localparam logic [PTR_W:0]    DEPTH_PTR   = (PTR_W + 1)'(PIPE_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_ADDR  = ADDR_W'(PIPE_DEPTH);

  // Per-pipe and per-port state
  logic [CNT_W-1:0]    byte_count   [PIPE_COUNT];
  logic [PTR_W-1:0]    read_pointer [PIPE_COUNT];
  logic [PORT_NUM-1:0] port_open;

  // Stage behind the store read, and the output register
  logic              s1_valid;
  logic [2:0]        s1_status;
  logic [FILL_W-1:0] s1_fill;
  logic              s1_last;
  logic              s1_rd_hit;

  // Decode of the incoming item
  logic                  accept;
  logic                  s1_move;
  logic [1:0]            pipe_num;
  logic                  pipe_ok;
  logic [PIPE_IDX_W-1:0] pipe_idx;
  logic [PORT_IDX_W-1:0] port_idx;
  logic [PORT_IDX_W-1:0] other_idx;
  logic                  is_reader;
  logic [CNT_W-1:0]      cnt_cur;
  logic [PTR_W-1:0]      rp_cur;
  logic                  other_open;

  // Next values
  logic [CNT_W-1:0]    cnt_next;
  logic [PTR_W-1:0]    rp_next;
  logic [PORT_NUM-1:0] port_open_next;
  logic [2:0]          status_next;
  logic                wr_ok;
  logic                rd_ok;
  logic [CNT_W:0]      wp_sum;
  logic [PTR_W:0]      rp_inc;
  logic [PTR_W-1:0]    ring_pos;
  logic [ADDR_W-1:0]   mem_addr;
  logic [7:0]          mem_q;

  // Handshake: the result stage moves on when the output register frees up
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  assign pipe_num  = in_data.port[2:1];
  assign pipe_ok   = 32'(pipe_num) < PIPE_COUNT;
  assign pipe_idx  = PIPE_IDX_W'(pipe_num);
  assign is_reader = in_data.port[0];
  assign port_idx  = {pipe_idx, is_reader};
  assign other_idx = {pipe_idx, !is_reader};

  assign cnt_cur    = pipe_ok ? byte_count[pipe_idx] : '0;
  assign rp_cur     = pipe_ok ? read_pointer[pipe_idx] : '0;
  assign other_open = pipe_ok ? port_open[other_idx] : 1'b0;

  // Ring positions for the write slot and the advanced read pointer
  assign wp_sum = {1'b0, CNT_W'(rp_cur)} + {1'b0, cnt_cur};
  assign rp_inc = {1'b0, rp_cur} + (PTR_W + 1)'(1);

  // Work out the result and the state update for one item
  always_comb begin
    cnt_next       = cnt_cur;
    rp_next        = rp_cur;
    port_open_next = port_open;
    status_next    = ST_OK;
    wr_ok          = 1'b0;
    rd_ok          = 1'b0;
    ring_pos       = rp_cur;
    if (!pipe_ok) begin
      status_next = ST_WRONG_DIR;
    end else begin
      unique case (in_data.kind)
        KIND_OPEN: begin
          if (port_open[port_idx]) begin
            status_next = ST_IN_USE;
          end else begin
            port_open_next[port_idx] = 1'b1;
          end
        end
        KIND_CLOSE: begin
          port_open_next[port_idx] = 1'b0;
          if (!other_open) begin
            cnt_next = '0;
            rp_next  = '0;
          end
        end
        KIND_WRITE: begin
          if (is_reader) begin
            status_next = ST_WRONG_DIR;
          end else if (cnt_cur >= DEPTH_CNT) begin
            status_next = ST_WOULD_BLOCK;
          end else begin
            wr_ok    = 1'b1;
            cnt_next = cnt_cur + CNT_W'(1);
            ring_pos = (wp_sum >= DEPTH_SUM) ? PTR_W'(wp_sum - DEPTH_SUM) : PTR_W'(wp_sum);
          end
        end
        KIND_READ: begin
          if (!is_reader) begin
            status_next = ST_WRONG_DIR;
          end else if (cnt_cur == '0) begin
            status_next = other_open ? ST_WOULD_BLOCK : ST_EOS;
          end else begin
            rd_ok    = 1'b1;
            cnt_next = cnt_cur - CNT_W'(1);
            rp_next  = (rp_inc == DEPTH_PTR) ? '0 : PTR_W'(rp_inc);
          end
        end
        default: begin
          status_next = ST_WRONG_DIR;
        end
      endcase
    end
  end

  assign mem_addr = ADDR_W'(pipe_idx) * DEPTH_ADDR + ADDR_W'(ring_pos);

  // Byte store of all pipes, one ring per pipe
  mcpf_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_ok),
    .wr_addr (mem_addr),
    .wr_data (in_data.data_in),
    .rd_en   (accept && rd_ok),
    .rd_addr (mem_addr),
    .rd_data (mem_q)
  );

  // Update port flags and pipe counters on each transfer that names an existing pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      port_open <= '0;
      for (int i = 0; i < PIPE_COUNT; i++) begin
        byte_count[i]   <= '0;
        read_pointer[i] <= '0;
      end
    end else if (accept && pipe_ok) begin
      port_open              <= port_open_next;
      byte_count[pipe_idx]   <= cnt_next;
      read_pointer[pipe_idx] <= rp_next;
    end
  end

  // Result stage while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_fill   <= FILL_W'(cnt_next);
      s1_last   <= in_data.last_of_call;
      s1_rd_hit <= rd_ok;
    end
  end

  // Output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.status     <= s1_status;
      out_data.data_out   <= s1_rd_hit ? mem_q : 8'd0;
      out_data.fill_level <= s1_fill;
      out_data.last_out   <= s1_last;
    end
  end

endmodule

FILE: rtl/core/mcpf_checker.sv
// Port-level checks of the multichannel byte pipe block, bound to the top level
`timescale 1ns / 1ps
`include "multichannel_pipe_fifo_core_defines.svh"
module mcpf_checker #(
  parameter int PIPE_DEPTH = 4096
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input mcpf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mcpf_pkg::out_item_t out_data
);
  import mcpf_pkg::*;

  localparam logic [FILL_W:0] DEPTH_FILL = (FILL_W + 1)'(PIPE_DEPTH);

  // An offered item waits unchanged until its transfer
  `MCPF_ASSERT(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid && $stable(in_data), "offered item changed")

  // A stalled result stays offered and unchanged
  `MCPF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // Only a successful read carries a byte
  `MCPF_ASSERT(a_data_zero, clk, rst, out_valid && (out_data.status != ST_OK) |-> out_data.data_out == 8'd0, "byte on a failed item")

  // A pipe never reports more bytes than its depth
  `MCPF_ASSERT(a_fill_range, clk, rst, out_valid |-> {1'b0, out_data.fill_level} <= DEPTH_FILL, "fill level beyond depth")

  // Nothing is offered in the cycle after reset
  `MCPF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result offered after reset")

endmodule

bind multichannel_pipe_fifo_core mcpf_checker #(
  .PIPE_DEPTH (PIPE_DEPTH)
) u_mcpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the multichannel byte pipe core
`timescale 1ns / 1ps
module tb_top;
  import mcpf_pkg::*;

  localparam int PIPES       = 4;
  localparam int DEPTH       = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 130;
  localparam int BURST_ITEMS = 40;

  typedef enum int {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_t;

  // One stimulus row; a pinned row carries its own expected result
  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } op_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  multichannel_pipe_fifo_core #(
    .PIPE_DEPTH(DEPTH),
    .PIPE_COUNT(PIPES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the pipes
  logic [7:0] ring_mem [PIPES][DEPTH];
  int         rd_ptr [PIPES];
  int         byte_cnt [PIPES];
  bit         port_is_open [2*PIPES];

  op_row_t    op_queue[$];
  out_item_t  pending_results[$];
  op_row_t    cur_op;
  out_item_t  predicted;
  out_item_t  oldest;
  op_row_t    dir_rows [25];

  gap_mode_t  gap_mode    = GAP_NONE;
  int         hold_req    = 0;
  int         hold_taken  = 0;
  int         hold_left   = 0;
  int         stall_count = 0;
  int         err_count   = 0;
  int         gen_count   = 0;

  // Apply one operation to the shadow pipes and return the result it gives
  function automatic out_item_t next_pipe_result(in_item_t it);
    out_item_t r;
    int        p;
    int        peer;
    int        wp;
    r          = '0;
    r.status   = ST_OK;
    r.last_out = it.last_of_call;
    p          = int'(it.port) >> 1;
    peer       = int'(it.port) ^ 1;
    case (it.kind)
      KIND_OPEN: begin
        if (port_is_open[it.port]) r.status = ST_IN_USE;
        else port_is_open[it.port] = 1'b1;
      end
      KIND_CLOSE: begin
        port_is_open[it.port] = 1'b0;
        if (!port_is_open[peer]) begin
          byte_cnt[p] = 0;
          rd_ptr[p]   = 0;
        end
      end
      KIND_WRITE: begin
        if (it.port[0]) begin
          r.status = ST_WRONG_DIR;
        end else if (byte_cnt[p] >= DEPTH) begin
          r.status = ST_WOULD_BLOCK;
        end else begin
          wp = (rd_ptr[p] + byte_cnt[p]) % DEPTH;
          ring_mem[p][wp] = it.data_in;
          byte_cnt[p]++;
        end
      end
      KIND_READ: begin
        if (!it.port[0]) begin
          r.status = ST_WRONG_DIR;
        end else if (byte_cnt[p] == 0) begin
          r.status = port_is_open[peer] ? ST_WOULD_BLOCK : ST_EOS;
        end else begin
          r.data_out = ring_mem[p][rd_ptr[p]];
          rd_ptr[p]  = (rd_ptr[p] + 1) % DEPTH;
          byte_cnt[p]--;
        end
      end
    endcase
    r.fill_level = FILL_W'(byte_cnt[p]);
    return r;
  endfunction

  function automatic op_row_t row(logic [1:0] kind, logic [2:0] port, logic [7:0] data,
                                  logic last, bit pinned, logic [2:0] st, logic [7:0] dout,
                                  int fill);
    op_row_t r;
    r.item.kind          = kind;
    r.item.port          = port;
    r.item.data_in       = data;
    r.item.last_of_call  = last;
    r.pinned             = pinned;
    r.want.status        = st;
    r.want.data_out      = dout;
    r.want.fill_level    = FILL_W'(fill);
    r.want.last_out      = last;
    return r;
  endfunction

  function automatic bit send_gap();
    case (gap_mode)
      GAP_SEND: return $urandom_range(99) < 86;
      GAP_BOTH: return $urandom_range(99) < 20;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit recv_gap();
    case (gap_mode)
      GAP_RECV: return $urandom_range(99) < 86;
      GAP_BOTH: return $urandom_range(99) < 20;
      default:  return 1'b0;
    endcase
  endfunction

  task automatic push_op(logic [1:0] kind, logic [2:0] port, logic [7:0] data, logic last);
    op_queue.push_back(row(kind, port, data, last, 1'b0, ST_OK, 8'h00, 0));
    gen_count++;
  endtask

  // Typical life of one pipe: open, bursts of writes and reads, close both ends
  task automatic gen_session(int p);
    logic [2:0] wr;
    logic [2:0] rd;
    int         n;
    int         m;
    wr = 3'(2 * p);
    rd = 3'(2 * p + 1);
    push_op(KIND_OPEN, wr, 8'($urandom), 1'($urandom));
    if ($urandom_range(3) != 0) push_op(KIND_OPEN, rd, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 4)) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) push_op(KIND_WRITE, wr, 8'($urandom), 1'(i == n - 1));
      m = $urandom_range(0, n + 3);
      for (int i = 0; i < m; i++) push_op(KIND_READ, rd, 8'($urandom), 1'(i == m - 1));
      // Occasional misuse mixed into a session
      case ($urandom_range(7))
        0: push_op(KIND_OPEN, wr, 8'($urandom), 1'($urandom));
        1: push_op(KIND_WRITE, rd, 8'($urandom), 1'($urandom));
        2: push_op(KIND_READ, wr, 8'($urandom), 1'($urandom));
        default: ;
      endcase
    end
    if ($urandom_range(1)) begin
      // Writer leaves first: drain past the end of stream
      push_op(KIND_CLOSE, wr, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 40)) push_op(KIND_READ, rd, 8'($urandom), 1'($urandom));
      push_op(KIND_CLOSE, rd, 8'($urandom), 1'($urandom));
    end else begin
      push_op(KIND_CLOSE, rd, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 6)) push_op(KIND_WRITE, wr, 8'($urandom), 1'($urandom));
      push_op(KIND_CLOSE, wr, 8'($urandom), 1'($urandom));
    end
  endtask

  // Wait until every operation is accepted and every result is back
  task automatic drain();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  task automatic report_mismatch(bit has_want, out_item_t want, out_item_t got);
    err_count++;
    if (err_count <= 10) begin
      if (has_want)
        $display("mismatch: want st=%0d data=%02h fill=%0d last=%0d, got st=%0d data=%02h fill=%0d last=%0d",
                 want.status, want.data_out, want.fill_level, want.last_out,
                 got.status, got.data_out, got.fill_level, got.last_out);
      else
        $display("mismatch: unexpected result st=%0d data=%02h fill=%0d last=%0d",
                 got.status, got.data_out, got.fill_level, got.last_out);
    end
  endtask

  // Sender: predict on each transfer, hold an unaccepted item, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = next_pipe_result(cur_op.item);
        pending_results.push_back(cur_op.pinned ? cur_op.want : predicted);
      end
      if (in_valid && !in_ready) begin
        // hold the offered item
      end else if (op_queue.size() != 0 && !send_gap()) begin
        cur_op = op_queue.pop_front();
        in_valid <= 1'b1;
        in_data  <= cur_op.item;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_req;
    end else begin
      out_ready <= !recv_gap();
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch(1'b0, '0, out_data);
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.status !== oldest.status || out_data.data_out !== oldest.data_out ||
            out_data.fill_level !== oldest.fill_level || out_data.last_out !== oldest.last_out)
          report_mismatch(1'b1, oldest, out_data);
      end
    end
  end

  // Watchdog: give up when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      // From reset: empty pipe with closed writer, wrong directions
      row(KIND_READ,  3'd1, 8'h00, 1'b1, 1'b1, ST_EOS,       8'h00, 0),
      row(KIND_WRITE, 3'd1, 8'hFF, 1'b0, 1'b1, ST_WRONG_DIR, 8'h00, 0),
      row(KIND_READ,  3'd0, 8'h00, 1'b1, 1'b1, ST_WRONG_DIR, 8'h00, 0),
      // Double open, empty read with writer open, byte extremes
      row(KIND_OPEN,  3'd0, 8'h00, 1'b0, 1'b1, ST_OK,        8'h00, 0),
      row(KIND_OPEN,  3'd0, 8'h00, 1'b0, 1'b1, ST_IN_USE,    8'h00, 0),
      row(KIND_READ,  3'd1, 8'h00, 1'b0, 1'b1, ST_WOULD_BLOCK, 8'h00, 0),
      row(KIND_WRITE, 3'd0, 8'hFF, 1'b1, 1'b1, ST_OK,        8'h00, 1),
      row(KIND_WRITE, 3'd0, 8'h00, 1'b0, 1'b1, ST_OK,        8'h00, 2),
      row(KIND_READ,  3'd1, 8'h00, 1'b1, 1'b1, ST_OK,        8'hFF, 1),
      // Closing the writer with the reader closed empties the pipe
      row(KIND_CLOSE, 3'd0, 8'h00, 1'b0, 1'b1, ST_OK,        8'h00, 0),
      row(KIND_READ,  3'd1, 8'h00, 1'b0, 1'b1, ST_EOS,       8'h00, 0),
      // Close of a port that was never opened, then unpinned rows checked against the shadow pipes
      row(KIND_CLOSE, 3'd7, 8'h00, 1'b1, 1'b1, ST_OK,        8'h00, 0),
      row(KIND_OPEN,  3'd7, 8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_OPEN,  3'd6, 8'h00, 1'b1, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_WRITE, 3'd6, 8'hA5, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_WRITE, 3'd6, 8'h5A, 1'b1, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_CLOSE, 3'd7, 8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_READ,  3'd7, 8'h00, 1'b1, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_CLOSE, 3'd6, 8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_READ,  3'd7, 8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_OPEN,  3'd4, 8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_OPEN,  3'd5, 8'h00, 1'b1, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_WRITE, 3'd4, 8'h0F, 1'b0, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_READ,  3'd5, 8'hF0, 1'b1, 1'b0, ST_OK,        8'h00, 0),
      row(KIND_WRITE, 3'd3, 8'h3C, 1'b0, 1'b0, ST_OK,        8'h00, 0)
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows
    foreach (dir_rows[i]) op_queue.push_back(dir_rows[i]);
    drain();

    // Burst into pipe 1 under a long receiver hold-off, then read past empty
    hold_req++;
    push_op(KIND_OPEN, 3'd2, 8'h00, 1'b0);
    repeat (BURST_ITEMS) push_op(KIND_WRITE, 3'd2, 8'($urandom), 1'($urandom));
    push_op(KIND_WRITE, 3'd2, 8'h77, 1'b1);
    repeat (BURST_ITEMS + 2) push_op(KIND_READ, 3'd3, 8'($urandom), 1'($urandom));
    push_op(KIND_CLOSE, 3'd2, 8'h00, 1'b0);
    push_op(KIND_CLOSE, 3'd3, 8'h00, 1'b1);
    drain();

    // Random sessions and noise under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      gap_mode  = gap_mode_t'(ph);
      gen_count = 0;
      if (ph == int'(GAP_SEND)) hold_req++;
      while (gen_count < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80)
          gen_session($urandom_range(PIPES - 1));
        else
          push_op(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: multichannel_pipe_fifo_core.f
+incdir+rtl/core
rtl/core/mcpf_pkg.sv
rtl/core/mcpf_ram.sv
rtl/core/multichannel_pipe_fifo_core.sv
rtl/core/mcpf_checker.sv
tb/sv/tb_top.sv
